[rtl/tss_pkg.sv]
// ----------------------------------------------------------------------------
// tss_pkg
// shared types and constants of the turn step sequencer
// ----------------------------------------------------------------------------
package tss_pkg;

  // angle limits in 1/16 degree
  localparam int HALF_TURN = 2880;
  localparam int FULL_TURN = 5760;

  // band upper limits on the folded magnitude, 1/16 degree
  localparam int BAND1_MAX = 256;
  localparam int BAND2_MAX = 768;
  localparam int BAND3_MAX = 1536;
  localparam int BAND4_MAX = 2304;

  // reciprocals for exact division by 3 and 9 of values below 2^18
  localparam int RECIP_SHIFT = 21;
  localparam logic [19:0] RECIP_3 = 20'd699051;
  localparam logic [19:0] RECIP_9 = 20'd233017;

  // yaw output range, 1/256 degree
  localparam int YAW_MAX = 16383;
  localparam int YAW_MIN = -16384;

  // band of the folded magnitude; band k has k+1 fractions
  typedef enum logic [2:0] {
    BAND_1 = 3'd0,   // divisor 2
    BAND_2 = 3'd1,   // divisor 6
    BAND_3 = 3'd2,   // divisor 12
    BAND_4 = 3'd3,   // divisor 18
    BAND_5 = 3'd4    // divisor 24
  } tss_band_t;

  // per-turn context held by the sequencer
  typedef struct packed {
    logic               zero;     // zero angle: two plain zero steps
    logic               dir_neg;  // direction after folding is negative
    tss_band_t          band;
    logic signed [12:0] mag;      // folded magnitude, 1/16 degree
    logic signed [17:0] te_d;     // turning error times band divisor
  } tss_ctx_t;

endpackage

[rtl/turn_step_sequencer.sv]
// ----------------------------------------------------------------------------
// turn_step_sequencer
// expands a requested turn angle into a walking robot's yaw step sequence
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one turn request per item, in_turn_angle in 1/16 degree
//   out_* : one yaw step per item, out_last marks the closing zero step
//   cfg_* : writes the yaw bias (1/256 degree); always ready, write only
//           while no turn is in flight
// a turn of n fractions (n = 1..5 by band) gives 2n+1 steps, a zero angle
// gives two zero steps, so one request yields 2 to 11 output steps
// a request's first step passes the input register, then the step
// sequencer feeding the output register
// throughput: one step per cycle while the receiver keeps up, set by the step
// index counter walking the sequence; the input register takes the next
// request while the current one is still being stepped out
// a stalled receiver holds the output register, the sequencer waits and
// the input register fills, then in_ready drops
// reset clears all valids, the foot flag (left foot) and the yaw bias
// ----------------------------------------------------------------------------
module turn_step_sequencer
  import tss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // turn requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [13:0]  in_turn_angle,
  // yaw steps
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [14:0]  out_yaw_step,
  output logic                out_step_is_right,
  output logic                out_last,
  // yaw bias register
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic signed [12:0]  cfg_yaw_bias
);

  // config
  logic signed [12:0] te_r;

  // input register
  logic               in_v_r;
  logic signed [13:0] in_angle_r;

  // sequencer
  logic               seq_v_r;
  tss_ctx_t           ctx_r;
  tss_ctx_t           ctx_new;
  logic [3:0]         k_r;
  logic               foot_r;

  // output register
  logic               out_v_r;
  logic signed [14:0] out_yaw_r;
  logic               out_right_r;
  logic               out_last_r;

  // handshake and control
  logic               out_adv;
  logic               step_fire;
  logic               step_last;
  logic               seq_free;
  logic               load;
  logic               in_accept;
  logic signed [14:0] step_yaw;

  // request decode
  logic signed [14:0] a_ext;
  logic signed [14:0] abs_a;
  logic               fold;
  logic signed [14:0] mag_w;
  logic signed [17:0] te_ext;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      te_r <= '0;
    end else if (cfg_valid) begin
      te_r <= cfg_yaw_bias;
    end
  end

  // output register frees when empty or being taken
  assign out_adv   = !out_v_r || out_ready;
  assign step_fire = seq_v_r && out_adv;
  assign seq_free  = !seq_v_r || (step_fire && step_last);
  assign load      = in_v_r && seq_free;
  assign in_ready  = !in_v_r || load;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_accept) begin
      in_v_r <= 1'b1;
    end else if (load) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_angle_r <= in_turn_angle;
    end
  end

  // fold the angle the short way and pick the band
  always_comb begin
    a_ext = 15'(in_angle_r);
    abs_a = in_angle_r[13] ? -a_ext : a_ext;
    fold  = abs_a > 15'(HALF_TURN);
    mag_w = fold ? 15'(FULL_TURN) - abs_a : abs_a;

    ctx_new.zero    = (in_angle_r == 14'sd0);
    ctx_new.dir_neg = in_angle_r[13] ^ fold;
    ctx_new.mag     = mag_w[12:0];

    priority if (ctx_new.mag <= 13'(BAND1_MAX)) begin
      ctx_new.band = BAND_1;
    end else if (ctx_new.mag <= 13'(BAND2_MAX)) begin
      ctx_new.band = BAND_2;
    end else if (ctx_new.mag <= 13'(BAND3_MAX)) begin
      ctx_new.band = BAND_3;
    end else if (ctx_new.mag <= 13'(BAND4_MAX)) begin
      ctx_new.band = BAND_4;
    end else begin
      ctx_new.band = BAND_5;
    end

    // turning error scaled by the band divisor, as shift-adds
    te_ext = 18'(te_r);
    unique case (ctx_new.band)
      BAND_1:  ctx_new.te_d = te_ext <<< 1;
      BAND_2:  ctx_new.te_d = (te_ext <<< 2) + (te_ext <<< 1);
      BAND_3:  ctx_new.te_d = (te_ext <<< 3) + (te_ext <<< 2);
      BAND_4:  ctx_new.te_d = (te_ext <<< 4) + (te_ext <<< 1);
      BAND_5:  ctx_new.te_d = (te_ext <<< 4) + (te_ext <<< 3);
      default: ctx_new.te_d = te_ext <<< 1;
    endcase
  end

  // step sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_v_r <= 1'b0;
      k_r     <= '0;
    end else if (load) begin
      seq_v_r <= 1'b1;
      k_r     <= '0;
    end else if (step_fire && step_last) begin
      seq_v_r <= 1'b0;
    end else if (step_fire) begin
      k_r <= k_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctx_r <= ctx_new;
    end
  end

  tss_step_calc u_calc (
    .ctx      (ctx_r),
    .step_idx (k_r),
    .yaw_step (step_yaw),
    .is_last  (step_last)
  );

  // foot flag toggles once per emitted step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      foot_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (step_fire) begin
      foot_r  <= ~foot_r;
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_yaw_r   <= step_yaw;
      out_right_r <= ~foot_r;
      out_last_r  <= step_last;
    end
  end

  assign out_valid         = out_v_r;
  assign out_yaw_step      = out_yaw_r;
  assign out_step_is_right = out_right_r;
  assign out_last          = out_last_r;

endmodule

[rtl/tss_step_calc.sv]
// ----------------------------------------------------------------------------
// tss_step_calc
// yaw of one step of a turn sequence from the turn context and step index
// ----------------------------------------------------------------------------
module tss_step_calc
  import tss_pkg::*;
(
  input  tss_ctx_t            ctx,
  input  logic [3:0]          step_idx,
  output logic signed [14:0]  yaw_step,
  output logic                is_last
);

  logic [2:0]         nfrac;
  logic [3:0]         last_idx;
  logic [3:0]         frac_idx;
  logic signed [16:0] m16;
  logic signed [19:0] m16_ext;
  logic signed [19:0] cm;
  logic signed [19:0] num;
  logic [19:0]        absn_w;
  logic [17:0]        absn;
  logic [17:0]        y;
  logic [19:0]        recip;
  logic [37:0]        prod;
  logic [16:0]        q;
  logic               res_neg;
  logic signed [17:0] yaw_full;
  logic signed [14:0] yaw_sat;

  always_comb begin
    nfrac    = 3'(ctx.band) + 3'd1;
    last_idx = {nfrac, 1'b0};
    // rising through the fractions, then falling back
    if (step_idx < {1'b0, nfrac}) begin
      frac_idx = step_idx;
    end else begin
      frac_idx = last_idx - 4'd1 - step_idx;
    end
    is_last = ctx.zero ? (step_idx == 4'd1) : (step_idx == last_idx);

    m16     = $signed({ctx.mag, 4'b0000});
    m16_ext = 20'(m16);
    unique case (frac_idx)
      4'd0:    cm = m16_ext;
      4'd1:    cm = m16_ext <<< 1;
      default: cm = (m16_ext <<< 1) + m16_ext;
    endcase
    num     = cm + 20'(ctx.te_d);
    absn_w  = num[19] ? 20'(-num) : 20'(num);
    absn    = absn_w[17:0];

    // divide magnitude by the band divisor: shift, then 1/3 or 1/9 (band 1: shift only)
    unique case (ctx.band)
      BAND_1:  begin y = absn;      recip = RECIP_3; end
      BAND_2:  begin y = absn >> 1; recip = RECIP_3; end
      BAND_3:  begin y = absn >> 2; recip = RECIP_3; end
      BAND_4:  begin y = absn >> 1; recip = RECIP_9; end
      BAND_5:  begin y = absn >> 3; recip = RECIP_3; end
      default: begin y = absn >> 1; recip = RECIP_3; end
    endcase
    prod = 38'(y) * 38'(recip);
    if (ctx.band == BAND_1) begin
      q = absn[17:1];
    end else begin
      q = prod[37:RECIP_SHIFT];
    end

    res_neg  = num[19] ^ ctx.dir_neg;
    yaw_full = res_neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (yaw_full > 18'(YAW_MAX)) begin
      yaw_sat = 15'(YAW_MAX);
    end else if (yaw_full < 18'(YAW_MIN)) begin
      yaw_sat = 15'(YAW_MIN);
    end else begin
      yaw_sat = yaw_full[14:0];
    end

    yaw_step = (ctx.zero || is_last) ? 15'sd0 : yaw_sat;
  end

endmodule

[rtl/tss_checker.sv]
// ----------------------------------------------------------------------------
// tss_checker
// port-level checks of the turn step sequencer, bound to the top level
// ----------------------------------------------------------------------------
module tss_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [14:0]  out_yaw_step,
  input logic                out_step_is_right,
  input logic                out_last
);

  // a stalled step holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_yaw_step)
      && $stable(out_step_is_right) && $stable(out_last))
    else $error("stalled step changed");

  // closing step carries no yaw
  a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_yaw_step == 15'sd0)
    else $error("last step has nonzero yaw");

  // feet alternate between consecutive steps
  a_foot_alt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) ##1 (out_valid && out_ready)
      |-> out_step_is_right != $past(out_step_is_right))
    else $error("foot flag did not alternate");

  // reset empties the block
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not empty after reset");

endmodule

bind turn_step_sequencer tss_checker u_tss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_yaw_step      (out_yaw_step),
  .out_step_is_right (out_step_is_right),
  .out_last          (out_last)
);

[sim/tb_turn_step_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_turn_step_sequencer
// self-checking bench for the turn step sequencer
// ----------------------------------------------------------------------------
// turn requests go in through a valid/ready channel with random gaps; every
// accepted request is expanded here into its yaw step sequence, and each
// step taken from the block is compared field by field with the oldest
// pending one. a short directed table covers band limits, folding, full and
// zero turns and the turning error extremes, then random phases follow, each
// with its own turning error and idling mix
// ----------------------------------------------------------------------------
module tb_turn_step_sequencer;
  import tss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 4;
  localparam int PHASE_TURNS = 34;

  // one yaw step as the block should emit it
  typedef struct packed {
    logic signed [14:0] yaw;
    logic               right;
    logic               last;
  } yaw_step_t;

  // directed row: turning error to hold, angle, and an optional typed-in
  // sequence of n steps: n-1 copies of val, then the closing zero step
  typedef struct packed {
    int typed;
    int te;
    int angle;
    int n;
    int val;
  } turn_row_t;

  localparam int N_ROWS = 27;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [13:0] in_turn_angle = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [14:0] out_yaw_step;
  logic               out_step_is_right;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic signed [12:0] cfg_yaw_bias = '0;

  // typed-in expectation travelling with the request on the input channel
  logic               req_typed = 1'b0;
  int                 req_n = 0;
  int                 req_val = 0;

  // model state: turning error, support foot, steps still to come
  int                 te_model = 0;
  logic               foot_model = 1'b0;
  yaw_step_t          pending_steps[$];

  int                 mismatch_cnt = 0;
  int                 steps_seen = 0;
  int                 cycle_cnt = 0;

  // idling controls, written by the main sequence with nonblocking updates
  logic               tx_calm = 1'b0;
  logic               rx_calm = 1'b0;
  logic               hold_out_req = 1'b0;

  turn_row_t dir_rows [N_ROWS] = '{
    // reset value of the turning error
    '{1, 0,     0, 2,     0},   // zero angle: two plain zero steps
    '{1, 0,    16, 3,   128},   // one degree
    '{1, 0,   -16, 3,  -128},
    '{1, 0,   256, 3,  2048},   // top of the first band
    '{0, 0,   257, 0,     0},
    '{0, 0,   768, 0,     0},
    '{0, 0,   769, 0,     0},
    '{0, 0,  1536, 0,     0},
    '{0, 0,  1537, 0,     0},
    '{0, 0,  2304, 0,     0},
    '{0, 0,  2305, 0,     0},
    '{0, 0,  2880, 0,     0},   // half turn, no fold
    '{0, 0,  2881, 0,     0},   // just past half turn, folds and flips
    '{0, 0, -2881, 0,     0},
    '{0, 0,  5759, 0,     0},
    '{1, 0,  5760, 3,     0},   // full turn folds to nothing
    '{0, 0,  8191, 0,     0},   // beyond a full turn, fold goes negative
    '{0, 0, -8192, 0,     0},   // most negative angle, yaw saturates
    // turning error at its upper extreme
    '{1, 2048,     0, 2,     0},  // zero angle takes no turning error
    '{1, 2048,  5760, 3, -2048},  // full turn: flipped turning error only
    '{1, 2048, -5760, 3,  2048},
    '{0, 2048,  2880, 0,     0},
    '{0, 2048,    -1, 0,     0},
    // turning error at its lower extreme
    '{0, -2048,     1, 0,     0},
    '{0, -2048, -5759, 0,     0},
    '{1, -2048,  5760, 3,  2048},
    '{0, -2048,  2304, 0,     0}
  };

  // angles next to the band limits and the fold point
  int band_edges [14] = '{1, 256, 257, 768, 769, 1536, 1537, 2304, 2305,
                          2879, 2880, 2881, 5759, 5760};

  turn_step_sequencer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_turn_angle     (in_turn_angle),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_yaw_step      (out_yaw_step),
    .out_step_is_right (out_step_is_right),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_yaw_bias      (cfg_yaw_bias)
  );

  always #2 clk = ~clk;

  // one step: saturate, toggle the foot, queue it
  function automatic void queue_step(int yaw, logic last);
    yaw_step_t s;
    if (yaw < YAW_MIN) yaw = YAW_MIN;
    if (yaw > YAW_MAX) yaw = YAW_MAX;
    foot_model = ~foot_model;
    s.yaw   = 15'(yaw);
    s.right = foot_model;
    s.last  = last;
    pending_steps.insert(pending_steps.size(), s);
  endfunction

  // expand one turn request into its yaw steps
  function automatic void expand_turn(logic signed [13:0] angle);
    int        a;
    int        dir;
    int        mag;
    int        div;
    int        nfrac;
    int        coef;
    int        frac [5];
    tss_band_t band;
    a = angle;
    if (a == 0) begin
      // no turning error on either zero step
      queue_step(0, 1'b0);
      queue_step(0, 1'b1);
      return;
    end
    dir = (a < 0) ? -1 : 1;
    mag = (a < 0) ? -a : a;
    // fold the long way round into the short way, direction flips
    if (mag > HALF_TURN) begin
      mag = FULL_TURN - mag;
      dir = -dir;
    end
    if (mag <= BAND1_MAX)      band = BAND_1;
    else if (mag <= BAND2_MAX) band = BAND_2;
    else if (mag <= BAND3_MAX) band = BAND_3;
    else if (mag <= BAND4_MAX) band = BAND_4;
    else                       band = BAND_5;
    unique case (band)
      BAND_1:  div = 2;
      BAND_2:  div = 6;
      BAND_3:  div = 12;
      BAND_4:  div = 18;
      default: div = 24;
    endcase
    nfrac = int'(band) + 1;
    // fractions c*m/D in 1/256 degree plus turning error, cut toward zero
    for (int i = 0; i < nfrac; i++) begin
      coef = (i < 3) ? i + 1 : 3;
      frac[i] = dir * ((coef * mag * 16 + te_model * div) / div);
    end
    for (int i = 0; i < nfrac; i++) queue_step(frac[i], 1'b0);
    for (int i = nfrac - 1; i >= 0; i--) queue_step(frac[i], 1'b0);
    queue_step(0, 1'b1);
  endfunction

  // mostly uniform angles, some zeros and some right at the band limits
  function automatic int rand_angle();
    int pick;
    int a;
    pick = $urandom_range(0, 15);
    if (pick == 0) a = 0;
    else if (pick <= 4) begin
      a = band_edges[$urandom_range(0, 13)];
      if ($urandom_range(0, 1) != 0) a = -a;
    end else a = $urandom_range(0, 2 * FULL_TURN) - FULL_TURN;
    return a;
  endfunction

  // step check and turn expansion, both on the rising edge
  always @(posedge clk) begin
    yaw_step_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        steps_seen++;
        if (pending_steps.size() == 0) begin
          $error("unexpected step: yaw_step %0d step_is_right %0b last %0b",
                 out_yaw_step, out_step_is_right, out_last);
          mismatch_cnt++;
        end else begin
          want = pending_steps.pop_front();
          if (out_yaw_step !== want.yaw) begin
            $error("yaw_step: expected %0d, got %0d", want.yaw, out_yaw_step);
            mismatch_cnt++;
          end
          if (out_step_is_right !== want.right) begin
            $error("step_is_right: expected %0b, got %0b", want.right, out_step_is_right);
            mismatch_cnt++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_last);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (req_typed) begin
          // sequence read straight off the table
          repeat (req_n - 1) queue_step(req_val, 1'b0);
          queue_step(0, 1'b1);
        end else begin
          expand_turn(in_turn_angle);
        end
      end
    end
  end

  // step receiver: a random stall per step, plus one long hold on request
  // so that the block backs up into its input
  int   rx_gap = 0;
  int   rx_hold = 0;
  int   rx_seen = 0;
  logic hold_served = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_out_req && !hold_served) begin
        hold_served = 1'b1;
        rx_hold = 120;
      end
      if (rx_seen != steps_seen) begin
        rx_seen = steps_seen;
        rx_gap = rx_calm ? 0 : $urandom_range(0, 8);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one turn request; entered and left on a falling edge, valid stays
  // high afterwards so back-to-back requests need no gap
  task automatic send_turn(int angle, logic typed, int n, int val);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_turn_angle <= 14'(angle);
    req_typed     <= typed;
    req_n         <= n;
    req_val       <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop the request, let every pending step drain, then settle
  task automatic wait_drained(int settle);
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_yaw_bias(int te);
    cfg_valid    <= 1'b1;
    cfg_yaw_bias <= 13'(te);
    do @(posedge clk); while (!cfg_ready);
    te_model = te;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int te_cur;
    int te;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, turning error changed only with the block idle
    te_cur = 0;
    for (int i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].te != te_cur) begin
        wait_drained(6);
        te_cur = dir_rows[i].te;
        write_yaw_bias(te_cur);
      end
      send_turn(dir_rows[i].angle, dir_rows[i].typed != 0, dir_rows[i].n,
                dir_rows[i].val);
    end

    // random phases
    //   0: random idling on both sides
    //   1: no idling at all
    //   2: sender flat out while the receiver holds off for a long stretch
    //   3: random idling, sender pauses mid-phase until all steps are out
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_drained(6);
      tx_calm <= (p == 1 || p == 2);
      rx_calm <= (p == 1);
      te = $urandom_range(0, 4096) - 2048;
      write_yaw_bias(te);
      if (p == 2) hold_out_req <= 1'b1;
      for (int k = 0; k < PHASE_TURNS; k++) begin
        if (p == 3 && k == PHASE_TURNS / 2) wait_drained(0);
        send_turn(rand_angle(), 1'b0, 0, 0);
      end
    end

    wait_drained(10);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
